// ----- design/mexp_pkg.sv -----
// Shared types and constants for the modular exponentiation block.
package mexp_pkg;

   localparam int FIELD_WIDTH    = 32;
   localparam int CSR_ADDR_WIDTH = 2;

   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_MODULUS   = 2'd0;
   localparam logic [FIELD_WIDTH-1:0]    MODULUS_RESET  = 32'd2;

   // Operand selection when a modular multiply is set up.
   localparam logic [1:0] SETUP_NONE     = 2'd0;
   localparam logic [1:0] SETUP_SQUARE   = 2'd1;
   localparam logic [1:0] SETUP_MULTIPLY = 2'd2;

   typedef struct packed {
      logic       load;
      logic       step;
      logic [1:0] setup;
      logic       store_base;
      logic       store_acc;
      logic       exp_shift;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic exp_msb;
   } status_type;

endpackage

// ----- design/mexp_req_if.sv -----
// Input channel carrying a base and an exponent.
interface mexp_req_if;
   logic                             valid;
   logic                             ready;
   logic [mexp_pkg::FIELD_WIDTH-1:0] base_value;
   logic [mexp_pkg::FIELD_WIDTH-1:0] exponent_value;

   modport source (output valid, output base_value, output exponent_value, input ready);
   modport sink   (input valid, input base_value, input exponent_value, output ready);
endinterface

// ----- design/mexp_rsp_if.sv -----
// Result channel carrying one power result.
interface mexp_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [mexp_pkg::FIELD_WIDTH-1:0] power_result;

   modport source (output valid, output power_result, input ready);
   modport sink   (input valid, input power_result, output ready);
endinterface

// ----- design/modular_exponentiation.sv -----
// Top level of the modular exponentiation block with its register port.
//
// This block computes base_value to the power exponent_value modulo the
// modulus register, scanning the exponent from its most significant set bit
// with a square and a conditional multiply per bit. Only the low
// OPERAND_WIDTH bits of the base, the exponent and the modulus are used. An
// exponent of zero gives one modulo the modulus, a modulus of one gives zero,
// and a modulus that is zero in its low OPERAND_WIDTH bits gives zero. The
// block works on one transaction at a time. All arithmetic goes through one
// bit-serial interleaved modular multiplier that takes the multiplier bits
// one at a time. A transaction first reduces the base, then for each exponent
// bit from the top set bit downwards squares and, when the bit is set, also
// multiplies, after stepping over any leading zero bits; it ends by loading
// the result register. A finished result waits in an output register, and
// the next transaction is accepted while it waits. The modulus is written
// through the APB-style port at byte address 0 and resets to 2; it should
// only be written while no transaction is in flight.
module modular_exponentiation #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   mexp_req_if.sink                            req_port,
   mexp_rsp_if.source                          rsp_port,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mexp_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [mexp_pkg::FIELD_WIDTH-1:0]    csr_pwdata,
   output logic [mexp_pkg::FIELD_WIDTH-1:0]    csr_prdata,
   output logic                                csr_pready
);

   mexp_pkg::cmd_type    cmd;
   mexp_pkg::status_type status;

   logic [mexp_pkg::FIELD_WIDTH-1:0] modulus_ff, modulus_in;
   logic                             csr_write;

   // The register port never stalls; a write lands in the access cycle.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr == mexp_pkg::ADDR_MODULUS);
   assign modulus_in = csr_write ? csr_pwdata : modulus_ff;
   assign csr_prdata = (csr_paddr == mexp_pkg::ADDR_MODULUS) ? modulus_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= mexp_pkg::MODULUS_RESET;
      end else begin
         modulus_ff <= modulus_in;
      end
   end

   // The controller sequences the reduction, squares and multiplies.
   mexp_ctrl #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_ready (rsp_port.ready),
      .rsp_valid (rsp_port.valid),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the operands, the multiplier and the output register.
   mexp_dp #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_dp (
      .clock          (clock),
      .cmd            (cmd),
      .status         (status),
      .modulus_value  (modulus_ff),
      .base_value     (req_port.base_value),
      .exponent_value (req_port.exponent_value),
      .power_result   (rsp_port.power_result)
   );

endmodule

// ----- design/mexp_ctrl.sv -----
// Sequencing state machine for the square-and-multiply exponentiation.
module mexp_ctrl #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   input  mexp_pkg::status_type status,
   output mexp_pkg::cmd_type    cmd
);

   localparam int CW = $clog2(OPERAND_WIDTH);
   localparam int BW = $clog2(OPERAND_WIDTH + 1);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_REDUCE  = 4'd1;
   localparam logic [3:0] ST_RED_END = 4'd2;
   localparam logic [3:0] ST_SCAN    = 4'd3;
   localparam logic [3:0] ST_SQUARE  = 4'd4;
   localparam logic [3:0] ST_SQ_END  = 4'd5;
   localparam logic [3:0] ST_MUL_SET = 4'd6;
   localparam logic [3:0] ST_MULT    = 4'd7;
   localparam logic [3:0] ST_MUL_END = 4'd8;
   localparam logic [3:0] ST_FINISH  = 4'd9;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] mul_cnt_ff, mul_cnt_in;
   logic [BW-1:0] bit_cnt_ff, bit_cnt_in;
   logic          started_ff, started_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          mul_last;

   assign mul_last  = (mul_cnt_ff == CW'(OPERAND_WIDTH - 1));
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      mul_cnt_in   = mul_cnt_ff;
      bit_cnt_in   = bit_cnt_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load   = 1'b1;
               mul_cnt_in = '0;
               bit_cnt_in = '0;
               started_in = 1'b0;
               state_in   = ST_REDUCE;
            end
         end
         ST_REDUCE, ST_SQUARE, ST_MULT: begin
            cmd.step = 1'b1;
            if (mul_last) begin
               mul_cnt_in = '0;
               if (state_ff == ST_REDUCE) begin
                  state_in = ST_RED_END;
               end else if (state_ff == ST_SQUARE) begin
                  state_in = ST_SQ_END;
               end else begin
                  state_in = ST_MUL_END;
               end
            end else begin
               mul_cnt_in = mul_cnt_ff + 1'b1;
            end
         end
         ST_RED_END: begin
            cmd.store_base = 1'b1;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            if (bit_cnt_ff == BW'(OPERAND_WIDTH)) begin
               state_in = ST_FINISH;
            end else if (!started_ff && !status.exp_msb) begin
               // Leading zero bits leave the accumulator at one mod m.
               cmd.exp_shift = 1'b1;
               bit_cnt_in    = bit_cnt_ff + 1'b1;
            end else begin
               cmd.setup  = mexp_pkg::SETUP_SQUARE;
               started_in = 1'b1;
               state_in   = ST_SQUARE;
            end
         end
         ST_SQ_END: begin
            cmd.store_acc = 1'b1;
            if (status.exp_msb) begin
               state_in = ST_MUL_SET;
            end else begin
               cmd.exp_shift = 1'b1;
               bit_cnt_in    = bit_cnt_ff + 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_MUL_SET: begin
            cmd.setup = mexp_pkg::SETUP_MULTIPLY;
            state_in  = ST_MULT;
         end
         ST_MUL_END: begin
            cmd.store_acc = 1'b1;
            cmd.exp_shift = 1'b1;
            bit_cnt_in    = bit_cnt_ff + 1'b1;
            state_in      = ST_SCAN;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mul_cnt_ff   <= '0;
         bit_cnt_ff   <= '0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mul_cnt_ff   <= mul_cnt_in;
         bit_cnt_ff   <= bit_cnt_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- design/mexp_dp.sv -----
// Datapath: operand registers and a bit-serial interleaved modular multiplier.
module mexp_dp #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic                             clock,
   input  mexp_pkg::cmd_type                cmd,
   output mexp_pkg::status_type             status,
   input  logic [mexp_pkg::FIELD_WIDTH-1:0] modulus_value,
   input  logic [mexp_pkg::FIELD_WIDTH-1:0] base_value,
   input  logic [mexp_pkg::FIELD_WIDTH-1:0] exponent_value,
   output logic [mexp_pkg::FIELD_WIDTH-1:0] power_result
);

   localparam int W  = OPERAND_WIDTH;
   localparam int FW = mexp_pkg::FIELD_WIDTH;

   logic [W-1:0]  m_ff, m_in;
   logic [W-1:0]  exp_ff, exp_in;
   logic [W-1:0]  base_ff, base_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  x_ff, x_in;
   logic [W-1:0]  y_ff, y_in;
   logic [W-1:0]  r_ff, r_in;
   logic [FW-1:0] result_ff, result_in;

   logic [W-1:0] m_new;
   logic [W-1:0] one_mod;
   logic [W:0]   dbl;
   logic [W:0]   dbl_red;
   logic [W:0]   sum;
   logic [W:0]   sum_red;
   logic [W-1:0] step_r;

   // One mod m: zero for a modulus of one, else one.
   assign m_new   = modulus_value[W-1:0];
   assign one_mod = (m_new == W'(1)) ? '0 : W'(1);

   // r <- 2r mod m, then add x when the current multiplier bit is set.
   // x is always below m, so one conditional subtraction suffices each time.
   always_comb begin
      dbl     = {r_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, m_ff}) ? (dbl - {1'b0, m_ff}) : dbl;
      sum     = {1'b0, dbl_red[W-1:0]} + {1'b0, x_ff};
      sum_red = (sum >= {1'b0, m_ff}) ? (sum - {1'b0, m_ff}) : sum;
      step_r  = y_ff[W-1] ? sum_red[W-1:0] : dbl_red[W-1:0];
   end

   assign status.exp_msb = exp_ff[W-1];
   assign power_result   = result_ff;

   always_comb begin
      m_in      = m_ff;
      exp_in    = exp_ff;
      base_in   = base_ff;
      acc_in    = acc_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      r_in      = r_ff;
      result_in = result_ff;
      if (cmd.load) begin
         // Base reduction is the product one * base mod m.
         m_in   = m_new;
         exp_in = exponent_value[W-1:0];
         y_in   = base_value[W-1:0];
         x_in   = one_mod;
         acc_in = one_mod;
         r_in   = '0;
      end else begin
         if (cmd.step) begin
            r_in = step_r;
            y_in = {y_ff[W-2:0], 1'b0};
         end
         case (cmd.setup)
            mexp_pkg::SETUP_SQUARE: begin
               x_in = acc_ff;
               y_in = acc_ff;
               r_in = '0;
            end
            mexp_pkg::SETUP_MULTIPLY: begin
               x_in = acc_ff;
               y_in = base_ff;
               r_in = '0;
            end
            default: begin
            end
         endcase
         if (cmd.store_base) begin
            base_in = r_ff;
         end
         if (cmd.store_acc) begin
            acc_in = r_ff;
         end
         if (cmd.exp_shift) begin
            exp_in = {exp_ff[W-2:0], 1'b0};
         end
         if (cmd.out_load) begin
            // A zero modulus has no residue and gives zero.
            result_in = (m_ff == '0) ? '0 : FW'(acc_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      m_ff      <= m_in;
      exp_ff    <= exp_in;
      base_ff   <= base_in;
      acc_ff    <= acc_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      r_ff      <= r_in;
      result_ff <= result_in;
   end

endmodule

// ----- design/mexp_checker.sv -----
// Port-level checks for the modular exponentiation block, bound to its top level.
module mexp_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [mexp_pkg::FIELD_WIDTH-1:0] power_result
);

   // Only one transaction is in work at a time.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted while a transaction was in work");

   // A new result appears just as the block returns to accepting input.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result presented while the block was still busy");

   // No new result may appear too early after an accepted transaction.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> ##2 !$rose(rsp_valid))
      else $error("result appeared too early after acceptance");

   // A waiting result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(power_result)))
      else $error("waiting result dropped or changed");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_port.valid),
   .req_ready    (req_port.ready),
   .rsp_valid    (rsp_port.valid),
   .rsp_ready    (rsp_port.ready),
   .power_result (rsp_port.power_result)
);

// ----- tb/mexp_result_checker.sv -----
`timescale 1ns / 1ps
// Watches the channels of the modular exponentiation block, predicts each power and compares.
module mexp_result_checker #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [mexp_pkg::FIELD_WIDTH-1:0]    req_base_value,
   input  logic [mexp_pkg::FIELD_WIDTH-1:0]    req_exponent_value,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [mexp_pkg::FIELD_WIDTH-1:0]    rsp_power_result,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic                                csr_pready,
   input  logic [mexp_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [mexp_pkg::FIELD_WIDTH-1:0]    csr_pwdata,
   output int                                  error_count,
   output int                                  pending_count
);

   typedef struct packed {
      logic [mexp_pkg::FIELD_WIDTH-1:0] base_value;
      logic [mexp_pkg::FIELD_WIDTH-1:0] exponent_value;
      logic [mexp_pkg::FIELD_WIDTH-1:0] modulus;
      logic [mexp_pkg::FIELD_WIDTH-1:0] power_result;
   } power_case_type;

   logic [mexp_pkg::FIELD_WIDTH-1:0] modulus_setting;
   power_case_type                   expected_powers[$];

   // Square and multiply over the full operand width; leading zero bits only square a one.
   function automatic logic [mexp_pkg::FIELD_WIDTH-1:0] power_modulo(
      input logic [mexp_pkg::FIELD_WIDTH-1:0] base_in,
      input logic [mexp_pkg::FIELD_WIDTH-1:0] exponent_in,
      input logic [mexp_pkg::FIELD_WIDTH-1:0] modulus_in
   );
      logic [63:0] operand_mask;
      logic [63:0] reduced_modulus;
      logic [63:0] reduced_base;
      logic [63:0] exponent_bits;
      logic [63:0] running;
      int          bit_index;
      operand_mask    = (64'd1 << OPERAND_WIDTH) - 64'd1;
      reduced_modulus = {32'd0, modulus_in} & operand_mask;
      if (reduced_modulus == 64'd0) begin
         return '0;
      end
      reduced_base  = ({32'd0, base_in} & operand_mask) % reduced_modulus;
      exponent_bits = {32'd0, exponent_in} & operand_mask;
      running       = 64'd1 % reduced_modulus;
      for (bit_index = OPERAND_WIDTH - 1; bit_index >= 0; bit_index--) begin
         running = (running * running) % reduced_modulus;
         if (exponent_bits[bit_index]) begin
            running = (running * reduced_base) % reduced_modulus;
         end
      end
      return running[mexp_pkg::FIELD_WIDTH-1:0];
   endfunction

   task automatic report_failure(input string detail);
      $display("%0t ns: %s", $time, detail);
      error_count++;
   endtask

   always @(posedge clock) begin
      power_case_type oldest;
      power_case_type fresh;
      if (reset) begin
         expected_powers.delete();
         modulus_setting <= mexp_pkg::MODULUS_RESET;
         pending_count   <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == mexp_pkg::ADDR_MODULUS) begin
            modulus_setting <= csr_pwdata;
         end
         // The result side is handled first so that a stray result never takes the
         // expectation of a transaction accepted at the same edge.
         if (rsp_valid && rsp_ready) begin
            if (expected_powers.size() == 0) begin
               report_failure($sformatf("power_result %h arrived with no transaction outstanding",
                                        rsp_power_result));
            end else begin
               oldest = expected_powers.pop_front();
               if (rsp_power_result !== oldest.power_result) begin
                  report_failure($sformatf(
                     "power_result %h, expected %h (base %h, exponent %h, modulus %h)",
                     rsp_power_result, oldest.power_result, oldest.base_value,
                     oldest.exponent_value, oldest.modulus));
               end
            end
         end
         if (req_valid && req_ready) begin
            fresh.base_value     = req_base_value;
            fresh.exponent_value = req_exponent_value;
            fresh.modulus        = modulus_setting;
            fresh.power_result   = power_modulo(req_base_value, req_exponent_value,
                                                modulus_setting);
            expected_powers.push_back(fresh);
         end
         pending_count <= expected_powers.size();
      end
   end

endmodule

// ----- tb/modular_exponentiation_test.sv -----
`timescale 1ns / 1ps
// Top of the modular exponentiation testbench: clock, reset, stimulus, register writes and verdict.
module modular_exponentiation_test;

   localparam int     OPERAND_WIDTH   = 32;
   localparam int     CLOCK_PERIOD    = 20;
   localparam int     RESET_CYCLES    = 10;
   localparam int     RANDOM_PHASES   = 6;
   localparam int     ITEMS_PER_PHASE = 45;
   localparam int     DRAIN_CYCLES    = 2400;
   localparam int     SETTLE_CYCLES   = 8;
   // Far beyond the slowest correct run: every transaction at full length and every
   // result held up by the longest stall of the receiver and the sender.
   localparam longint TIMEOUT_CYCLES  = 8_000_000;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                csr_psel;
   logic                                csr_penable;
   logic                                csr_pwrite;
   logic [mexp_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [mexp_pkg::FIELD_WIDTH-1:0]    csr_pwdata;
   logic [mexp_pkg::FIELD_WIDTH-1:0]    csr_prdata;
   logic                                csr_pready;
   logic                                result_ready = 1'b0;
   int                                  ready_hold = 0;
   int                                  error_count;
   int                                  pending_count;
   bit                                  sender_steady;
   logic [mexp_pkg::FIELD_WIDTH-1:0]    modulus_now;

   mexp_req_if req_chan ();
   mexp_rsp_if rsp_chan ();

   assign rsp_chan.ready = result_ready;

   modular_exponentiation #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_chan),
      .rsp_port    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // The checker sits beside the block, sees every transaction on both channels
   // and every register write, and hands back its failure and outstanding counts.
   mexp_result_checker #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_chan.valid),
      .req_ready          (req_chan.ready),
      .req_base_value     (req_chan.base_value),
      .req_exponent_value (req_chan.exponent_value),
      .rsp_valid          (rsp_chan.valid),
      .rsp_ready          (rsp_chan.ready),
      .rsp_power_result   (rsp_chan.power_result),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_pready         (csr_pready),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .error_count        (error_count),
      .pending_count      (pending_count)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Idle lengths: mostly none or short, now and then one long enough to
   // span a good part of an exponentiation.
   function automatic int random_gap();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) begin
         return 0;
      end else if (pick < 85) begin
         return $urandom_range(3, 1);
      end else if (pick < 97) begin
         return $urandom_range(30, 4);
      end
      return $urandom_range(2500, 100);
   endfunction

   // Bases lean towards the edges: zero, one, all ones and values at or just
   // above the modulus, which must be reduced before the first multiply.
   function automatic logic [mexp_pkg::FIELD_WIDTH-1:0] random_base(
      input logic [mexp_pkg::FIELD_WIDTH-1:0] modulus
   );
      int pick;
      pick = $urandom_range(99);
      if (pick < 50) begin
         return $urandom();
      end else if (pick < 60) begin
         return '0;
      end else if (pick < 65) begin
         return 32'd1;
      end else if (pick < 75) begin
         return '1;
      end else if (pick < 85) begin
         return modulus + $urandom_range(3);
      end
      return $urandom_range(255);
   endfunction

   // Short exponents keep the run brisk; full-width ones exercise every bit.
   function automatic logic [mexp_pkg::FIELD_WIDTH-1:0] random_exponent();
      int pick;
      pick = $urandom_range(99);
      if (pick < 45) begin
         return $urandom();
      end else if (pick < 75) begin
         return $urandom_range(255);
      end else if (pick < 85) begin
         return '0;
      end else if (pick < 95) begin
         return $urandom_range(2, 1);
      end
      return '1;
   endfunction

   function automatic logic [mexp_pkg::FIELD_WIDTH-1:0] random_modulus(input int phase);
      case (phase)
         0: begin
            return $urandom();
         end
         1: begin
            return $urandom_range(1000, 2);
         end
         2: begin
            return 32'h8000_0000;
         end
         3: begin
            return $urandom() | 32'h8000_0001;
         end
         4: begin
            return '1;
         end
         default: begin
            return 32'd3;
         end
      endcase
   endfunction

   // The receiver alternates between stalls of random length and stretches of
   // readiness, some of them long enough that several results pass unhindered.
   always @(posedge clock) begin
      if (reset) begin
         result_ready <= 1'b0;
         ready_hold   <= 0;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(2) == 0) begin
         result_ready <= 1'b0;
         ready_hold   <= random_gap();
      end else begin
         result_ready <= 1'b1;
         ready_hold   <= ($urandom_range(9) == 0) ? $urandom_range(4000, 1000)
                                                  : $urandom_range(40);
      end
   end

   // Presents one transaction and waits for the block to take it. Ready is
   // sampled at the falling edge, where nothing is changing, so the decision
   // holds for the rising edge that follows. Valid stays high into the next
   // call when no gap is drawn, so it is never lowered and raised in one step.
   task automatic issue_request(input logic [mexp_pkg::FIELD_WIDTH-1:0] base_value,
                                input logic [mexp_pkg::FIELD_WIDTH-1:0] exponent_value);
      int gap;
      req_chan.valid          <= 1'b1;
      req_chan.base_value     <= base_value;
      req_chan.exponent_value <= exponent_value;
      do @(negedge clock); while (req_chan.ready !== 1'b1);
      @(posedge clock);
      if (!sender_steady) begin
         gap = random_gap();
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stops the sender and waits until every expected result has been handed over.
   task automatic drain_results(input int extra_cycles);
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      @(posedge clock);
      repeat (extra_cycles) @(posedge clock);
   endtask

   // A register write is a setup cycle followed by an access cycle that lasts
   // until pready is seen high.
   task automatic write_modulus(input logic [mexp_pkg::FIELD_WIDTH-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= mexp_pkg::ADDR_MODULUS;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(negedge clock); while (csr_pready !== 1'b1);
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      modulus_now = value;
   endtask

   initial begin
      int phase;
      int item;
      reset                   <= 1'b1;
      req_chan.valid          <= 1'b0;
      req_chan.base_value     <= '0;
      req_chan.exponent_value <= '0;
      csr_psel                <= 1'b0;
      csr_penable             <= 1'b0;
      csr_pwrite              <= 1'b0;
      csr_paddr               <= mexp_pkg::ADDR_MODULUS;
      csr_pwdata              <= '0;
      sender_steady            = 1'b0;
      modulus_now              = mexp_pkg::MODULUS_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The modulus is left at its reset value of two for the first few transactions.
      issue_request(32'd3, 32'd5);
      issue_request(32'd4, 32'd7);
      issue_request('1, '0);
      issue_request(32'hFFFF_FFFE, '1);

      // The largest prime below two to the 32: zero base and exponent, all-ones
      // operands, a base equal to and just above the modulus, and single-bit exponents.
      drain_results(SETTLE_CYCLES);
      write_modulus(32'hFFFF_FFFB);
      issue_request('0, '0);
      issue_request('0, 32'd5);
      issue_request(32'd1, '1);
      issue_request('1, '1);
      issue_request(32'hFFFF_FFFB, 32'd3);
      issue_request(32'hFFFF_FFFC, 32'd2);
      issue_request(32'd12345, 32'd1);
      issue_request(32'd2, 32'h8000_0000);
      issue_request(32'hDEAD_BEEF, 32'h7FFF_FFFF);
      issue_request(32'h5555_5555, 32'hAAAA_AAAA);
      issue_request(32'hAAAA_AAAA, 32'h5555_5555);

      // A modulus of one gives zero everywhere, even for a zero exponent.
      drain_results(SETTLE_CYCLES);
      write_modulus(32'd1);
      issue_request(32'd7, '0);
      issue_request('1, '1);

      // A modulus of zero has no residue and must also give zero.
      drain_results(SETTLE_CYCLES);
      write_modulus('0);
      issue_request(32'd5, '0);
      issue_request('1, 32'd3);

      // The largest modulus, where the widest products arise.
      drain_results(SETTLE_CYCLES);
      write_modulus('1);
      issue_request(32'hFFFF_FFFE, 32'd2);
      issue_request('1, 32'd9);

      // Back to the smallest meaningful modulus, written rather than from reset.
      drain_results(SETTLE_CYCLES);
      write_modulus(32'd2);
      issue_request(32'd3, '1);

      // Random transactions in phases, each under its own modulus. Phase 3, and now
      // and then another, runs the sender with no gaps at all; at least once mid-phase
      // the sender holds off until every outstanding result has come back.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_results(SETTLE_CYCLES);
         write_modulus(random_modulus(phase));
         sender_steady = (phase == 3) || ($urandom_range(3) == 0);
         for (item = 0; item < ITEMS_PER_PHASE; item++) begin
            issue_request(random_base(modulus_now), random_exponent());
            if ((phase == 1 && item == ITEMS_PER_PHASE / 2) || $urandom_range(99) == 0) begin
               drain_results(0);
            end
         end
      end

      drain_results(DRAIN_CYCLES);
      if (error_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Should the block hang, the run is ended here and counted as failed.
   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
